// ----- sv/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and codes for the block bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    localparam int FUNC_W = 2;
    localparam int BLK_W  = 16;
    localparam int CNT_W  = 13;
    localparam int STAT_W = 2;
    localparam int POS_W  = 17;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLAIM   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOFREE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_USED   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BLK_W-1:0]  block_number;
    } t_req;

    typedef struct packed {
        logic [CNT_W-1:0]  granted_block;
        logic              in_use;
        logic [STAT_W-1:0] status;
    } t_rsp;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_MOD,
        S_RESP
    } t_state;

endpackage

`default_nettype wire

// ----- sv/block_bitmap_allocator_top.sv -----
// ----------------------------------------------------------------------------
// block_bitmap_allocator_top
// First-fit block allocator over a used/free bitmap held in one memory.
// ----------------------------------------------------------------------------
// The bitmap lives in a word-wide memory of ceil(MAX_BLOCKS/WORD_BITS) entries;
// the user must keep WORD_BITS a power of two, which the block does not
// enforce. After reset a clearing pass writes one word per cycle, and input is
// held off until every word is cleared; configuration writes are taken
// throughout. One item is in work at a time. Alloc scans the bitmap word by
// word (the memory read port delivers one word a cycle). Claim, release and
// query go through accept, word/bit split, word read, then write-back and
// result; items decided at once (range errors, blocks outside the map, an
// empty count for alloc) go from accept straight to the result. A finished
// result sits in an output register while the next item is taken; that item
// then waits there until the register is emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module block_bitmap_allocator_top #(
    parameter int MAX_BLOCKS = 4096,
    parameter int WORD_BITS  = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [bba_pkg::CNT_W-1:0] i_cfg_data,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire bba_pkg::t_req             i_in,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output bba_pkg::t_rsp                  o_out
);

    import bba_pkg::*;

    localparam int NWORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int BW     = $clog2(WORD_BITS);

    logic [CNT_W-1:0] r_block_count;
    logic [CNT_W-1:0] w_count;

    logic                 w_wr_en;
    logic [AW-1:0]        w_wr_addr;
    logic [WORD_BITS-1:0] w_wr_data;
    logic                 w_rd_en;
    logic [AW-1:0]        w_rd_addr;
    logic [WORD_BITS-1:0] w_rd_data;
    logic                 w_div_start;
    logic [BLK_W-1:0]     w_div_num;
    logic                 w_div_done;
    logic [BLK_W-1:0]     w_div_quot;
    logic [BW-1:0]        w_div_rem;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= '0;
        end else if (i_cfg_valid) begin
            r_block_count <= i_cfg_data;
        end
    end

    // counts above capacity act as capacity
    assign w_count = (POS_W'(r_block_count) > POS_W'(MAX_BLOCKS)) ?
                     CNT_W'(MAX_BLOCKS) : r_block_count;

    bba_mem #(
        .DEPTH (NWORDS),
        .WIDTH (WORD_BITS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    bba_div #(
        .BW (BW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot),
        .o_rem   (w_div_rem)
    );

    bba_ctrl #(
        .WORD_BITS (WORD_BITS),
        .NWORDS    (NWORDS),
        .AW        (AW),
        .BW        (BW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_count     (w_count),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_div_start (w_div_start),
        .o_div_num   (w_div_num),
        .i_div_done  (w_div_done),
        .i_div_quot  (w_div_quot),
        .i_div_rem   (w_div_rem)
    );

endmodule

`default_nettype wire

// ----- sv/bba_mem.sv -----
// ----------------------------------------------------------------------------
// bba_mem
// Bitmap word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_mem #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32,
    parameter int AW    = 7
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/bba_div.sv -----
// ----------------------------------------------------------------------------
// bba_div
// Bit position to word/bit split: word index by shift, bit index by mask,
// registered, with done raised in the cycle after start.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_div #(
    parameter int BW = 5
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [bba_pkg::BLK_W-1:0]  i_num,
    output logic                            o_done,
    output logic      [bba_pkg::BLK_W-1:0]  o_quot,
    output logic      [BW-1:0]              o_rem
);

    import bba_pkg::*;

    logic             r_done;
    logic [BLK_W-1:0] r_quot;
    logic [BW-1:0]    r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num >> BW;
            r_rem  <= i_num[BW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ----- sv/bba_ctrl.sv -----
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: clearing pass, first-fit word scan, single-bit read-modify-write,
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ctrl #(
    parameter int WORD_BITS = 32,
    parameter int NWORDS    = 128,
    parameter int AW        = 7,
    parameter int BW        = 5
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [bba_pkg::CNT_W-1:0]  i_count,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire bba_pkg::t_req              i_in,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output bba_pkg::t_rsp                   o_out,
    output logic                            o_wr_en,
    output logic      [AW-1:0]              o_wr_addr,
    output logic      [WORD_BITS-1:0]       o_wr_data,
    output logic                            o_rd_en,
    output logic      [AW-1:0]              o_rd_addr,
    input  wire logic [WORD_BITS-1:0]       i_rd_data,
    output logic                            o_div_start,
    output logic      [bba_pkg::BLK_W-1:0]  o_div_num,
    input  wire logic                       i_div_done,
    input  wire logic [bba_pkg::BLK_W-1:0]  i_div_quot,
    input  wire logic [BW-1:0]              i_div_rem
);

    import bba_pkg::*;

    localparam int STORE_BITS = NWORDS * WORD_BITS;

    t_state r_state, n_state;
    logic [FUNC_W-1:0] r_func, n_func;
    logic [AW-1:0]     r_word, n_word;
    logic [POS_W-1:0]  r_base, n_base;
    logic [AW-1:0]     r_clr, n_clr;
    t_rsp              r_res, n_res;
    t_rsp              r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic [BLK_W-1:0]     w_adj;
    logic [POS_W-1:0]     w_cnt;
    logic [POS_W-1:0]     w_map_bits;
    logic                 w_in_map;
    logic [POS_W-1:0]     w_limit;
    logic [WORD_BITS-1:0] w_free;
    logic                 w_found;
    logic [BW-1:0]        w_sel;
    logic [POS_W-1:0]     w_grant;
    logic                 w_bit;

    assign w_adj      = i_in.block_number - BLK_W'(1);
    assign w_cnt      = POS_W'(i_count);
    assign w_map_bits = (w_cnt + POS_W'(7)) & ~POS_W'(7);
    assign w_in_map   = (POS_W'(w_adj) < w_map_bits) && (POS_W'(w_adj) < POS_W'(STORE_BITS));
    assign w_limit    = w_cnt - r_base;
    assign w_bit      = i_rd_data[i_div_rem];

    always_comb begin
        w_free  = '0;
        w_found = 1'b0;
        w_sel   = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            w_free[i] = ~i_rd_data[i] & (POS_W'(i) < w_limit);
        end
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w_free[i]) begin
                w_found = 1'b1;
                w_sel   = BW'(i);
            end
        end
    end

    assign w_grant = r_base + POS_W'(w_sel) + POS_W'(1);

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_word      = r_word;
        n_base      = r_base;
        n_clr       = r_clr;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_in_ready  = 1'b0;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_word;
        o_wr_data   = i_rd_data;
        o_rd_en     = 1'b0;
        o_rd_addr   = '0;
        o_div_start = 1'b0;
        o_div_num   = w_adj;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_clr;
                o_wr_data = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == AW'(NWORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_func = i_in.func;
                    n_res  = '{granted_block: '0, in_use: 1'b0, status: STAT_OK};
                    case (i_in.func)
                        FUNC_ALLOC: begin
                            if (i_count == '0) begin
                                n_res.status = STAT_NOFREE;
                                n_state      = S_RESP;
                            end else begin
                                o_rd_en = 1'b1;
                                n_word  = '0;
                                n_base  = '0;
                                n_state = S_SCAN;
                            end
                        end
                        FUNC_CLAIM: begin
                            if (i_in.block_number == '0 ||
                                POS_W'(i_in.block_number) > w_cnt) begin
                                n_res.status = STAT_RANGE;
                                n_state      = S_RESP;
                            end else begin
                                o_div_start = 1'b1;
                                n_state     = S_DIV;
                            end
                        end
                        FUNC_RELEASE: begin
                            if (!w_in_map) begin
                                n_state = S_RESP;
                            end else begin
                                o_div_start = 1'b1;
                                n_state     = S_DIV;
                            end
                        end
                        default: begin
                            if (!w_in_map) begin
                                n_res.in_use = 1'b1;
                                n_state      = S_RESP;
                            end else begin
                                o_div_start = 1'b1;
                                n_state     = S_DIV;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // read one word ahead while checking the current one
                o_rd_en   = (r_word != AW'(NWORDS - 1));
                o_rd_addr = r_word + 1'b1;
                if (w_found) begin
                    o_wr_en                = 1'b1;
                    o_wr_data[w_sel]       = 1'b1;
                    n_res.granted_block    = w_grant[CNT_W-1:0];
                    n_res.status           = STAT_OK;
                    n_state                = S_RESP;
                end else if (r_base + POS_W'(WORD_BITS) >= w_cnt) begin
                    n_res.status = STAT_NOFREE;
                    n_state      = S_RESP;
                end else begin
                    n_word = r_word + 1'b1;
                    n_base = r_base + POS_W'(WORD_BITS);
                end
            end
            S_DIV: begin
                if (i_div_done) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = i_div_quot[AW-1:0];
                    n_word    = i_div_quot[AW-1:0];
                    n_state   = S_MOD;
                end
            end
            S_MOD: begin
                n_state = S_RESP;
                case (r_func)
                    FUNC_CLAIM: begin
                        if (w_bit) begin
                            n_res.status = STAT_USED;
                        end else begin
                            o_wr_en              = 1'b1;
                            o_wr_data[i_div_rem] = 1'b1;
                        end
                    end
                    FUNC_RELEASE: begin
                        o_wr_en              = 1'b1;
                        o_wr_data[i_div_rem] = 1'b0;
                    end
                    FUNC_QUERY: begin
                        n_res.in_use = w_bit;
                    end
                    default: begin
                    end
                endcase
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func <= n_func;
        r_word <= n_word;
        r_base <= n_base;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire
